FILE: hw/rtl/sla_pkg.sv
// Shared types and constants for the scrolling lane allocator.
package sla_pkg;

  localparam int TRAVEL_W   = 15;  // crossing time, ms
  localparam int LANES_W    = 5;   // lane count register
  localparam int LEN_W      = 16;  // item length, pixels
  localparam int TIME_W     = 40;  // presentation time, ms
  localparam int START_W    = 42;  // stored start time, signed
  localparam int LANE_OUT_W = 5;   // lane field of a result
  localparam int LANE_IDX_W = 6;   // lane tag inside the scan pipeline
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TIME  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANES_IN_USE = 4'd1;

  localparam logic signed [START_W-1:0] START_RESET  = -42'sd10000;
  localparam logic        [LEN_W-1:0]   LENGTH_RESET = 16'd1;

  // One lane record as held in lane memory.
  typedef struct packed {
    logic        [LEN_W-1:0]   len;
    logic signed [START_W-1:0] start;
  } lane_rec_t;

  // Lane read issued into the test pipeline.
  typedef struct packed {
    logic                  vld;
    logic [LANE_IDX_W-1:0] idx;
  } chk_req_t;

  // Verdict leaving the test pipeline.
  typedef struct packed {
    logic                  vld;
    logic                  hit;
    logic [LANE_IDX_W-1:0] idx;
  } chk_res_t;

endpackage

FILE: hw/rtl/sla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sla_ram #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 30
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/sla_lane_check.sv
// Pipelined lane test: time difference, cross products, compare.
module sla_lane_check import sla_pkg::*; #(
  parameter int LINE_WIDTH = 1920
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                flush,
  input  chk_req_t            req,
  input  logic                ent_valid,
  input  lane_rec_t           rec,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [LEN_W-1:0]    item_length,
  input  logic [TRAVEL_W-1:0] travel,
  output chk_res_t            res,
  output logic                busy
);

  localparam int SUM_W  = $clog2(LINE_WIDTH + 65536);
  localparam int PROD_W = TRAVEL_W + SUM_W;
  localparam int D_W    = START_W + 1;

  // stage A inputs
  logic signed [D_W-1:0] start_ext;
  logic signed [D_W-1:0] now_ext;
  logic signed [D_W-1:0] d;
  logic                  d_neg;
  logic                  d_ge;
  logic [LEN_W-1:0]      p;

  // stage A registers
  logic                  a_vld_r;
  logic [LANE_IDX_W-1:0] a_idx_r;
  logic                  a_neg_r;
  logic                  a_ge_r;
  logic [TRAVEL_W-1:0]   a_d_r;
  logic [LEN_W-1:0]      a_p_r;

  // stage B products
  logic [TRAVEL_W-1:0]   diff;
  logic [SUM_W-1:0]      sum_l;
  logic [SUM_W-1:0]      sum_p;

  logic                  b_vld_r;
  logic [LANE_IDX_W-1:0] b_idx_r;
  logic                  b_neg_r;
  logic                  b_ge_r;
  logic [PROD_W-1:0]     prod_a_r;
  logic [PROD_W-1:0]     rhs_a_r;
  logic [PROD_W-1:0]     prod_b_r;
  logic [PROD_W-1:0]     rhs_b_r;

  // d = now - start; never-written lanes read as their reset record
  always_comb begin
    start_ext = ent_valid ? D_W'(rec.start) : D_W'(START_RESET);
    now_ext   = signed'(D_W'(now_ms));
    d         = now_ext - start_ext;
    d_neg     = d[D_W-1];
    d_ge      = !d_neg && (d >= signed'(D_W'(travel)));
    p         = ent_valid ? rec.len : LENGTH_RESET;
  end

  // Only 0 <= d < T needs products; d narrows to the travel width there.
  always_comb begin
    diff  = travel - a_d_r;
    sum_l = SUM_W'(LINE_WIDTH) + SUM_W'(item_length);
    sum_p = SUM_W'(LINE_WIDTH) + SUM_W'(a_p_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= req.vld && !flush;
      b_vld_r <= a_vld_r && !flush;
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r  <= req.idx;
    a_neg_r  <= d_neg;
    a_ge_r   <= d_ge;
    a_d_r    <= d[TRAVEL_W-1:0];
    a_p_r    <= p;
    b_idx_r  <= a_idx_r;
    b_neg_r  <= a_neg_r;
    b_ge_r   <= a_ge_r;
    prod_a_r <= PROD_W'(diff) * PROD_W'(sum_l);
    rhs_a_r  <= PROD_W'(LINE_WIDTH) * PROD_W'(travel);
    prod_b_r <= PROD_W'(sum_p) * PROD_W'(a_d_r);
    rhs_b_r  <= PROD_W'(a_p_r) * PROD_W'(travel);
  end

  // free: previous item gone (d >= T), or both tests pass; negative d refuses
  always_comb begin
    res.vld = b_vld_r;
    res.idx = b_idx_r;
    res.hit = b_ge_r ||
              (!b_neg_r && !(prod_a_r > rhs_a_r) && !(prod_b_r < rhs_b_r));
  end

  assign busy = a_vld_r || b_vld_r;

endmodule

FILE: hw/rtl/scrolling_lane_allocator.sv
// One item in work at a time; the scan reads the lane memory at one lane per cycle, in
// lane order, feeding the lane test pipeline (time difference, cross products, compare).
// It stops at the first free lane, or refuses the item once min(lanes_in_use, MAX_LANES)
// lanes are tested. A new item is accepted only in idle, after the previous result has
// been loaded into the output register.
// Reset (synchronous, active low): registers to 10000 ms and 14 lanes; every lane
// reads as length 1, start -10000 until written. No clearing pass.
module scrolling_lane_allocator import sla_pkg::*; #(
  parameter int MAX_LANES  = 30,
  parameter int LINE_WIDTH = 1920
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LEN_W-1:0]      in_item_length,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LANE_OUT_W-1:0] out_lane,
  output logic                  out_found,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int CNT_W  = $clog2(MAX_LANES + 1);

  localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = 15'd10000;
  localparam logic [TRAVEL_W-1:0] TRAVEL_MIN   = 15'd501;
  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX   = 15'd29999;
  localparam logic [LANES_W-1:0]  LANES_RESET  = 5'd14;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // configuration
  logic [TRAVEL_W-1:0]   travel_r;
  logic [LANES_W-1:0]    lanes_r;

  // control
  state_t                state_r;
  state_t                state_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W-1:0]      rd_idx_r;
  logic [LEN_W-1:0]      len_r;
  logic [TIME_W-1:0]     now_r;
  logic [MAX_LANES-1:0]  lane_vld_r;

  // first pipeline slot: memory read in flight
  logic                  s1_vld_r;
  logic [LANE_IDX_W-1:0] s1_idx_r;
  logic                  s1_ent_vld_r;

  logic [LANE_OUT_W-1:0] res_lane_r;
  logic                  res_found_r;
  logic                  out_valid_r;
  logic [LANE_OUT_W-1:0] out_lane_r;
  logic                  out_found_r;

  logic                  in_xfer;
  logic                  issue;
  logic                  hit;
  logic                  miss;
  logic                  out_load;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  lane_rec_t             wr_rec;
  logic [$bits(lane_rec_t)-1:0] ram_rdata;
  chk_req_t              chk_req;
  chk_res_t              chk_res;
  logic                  chk_busy;

  // ---------------------------------------------------------------------------
  // Configuration: out-of-range travel times and unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_r <= TRAVEL_RESET;
      lanes_r  <= LANES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TRAVEL_TIME) begin
        if (cfg_data >= TRAVEL_MIN && cfg_data <= TRAVEL_MAX) begin
          travel_r <= cfg_data;
        end
      end else if (cfg_index == REG_LANES_IN_USE) begin
        lanes_r <= cfg_data[LANES_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scan control. One lane read per cycle in lane order; the test pipeline
  // returns verdicts in the same order, so the first hit is the lowest free
  // lane. A hit writes the lane back and flushes the reads behind it.
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign count_nxt = (32'(lanes_r) > MAX_LANES) ? CNT_W'(MAX_LANES) : CNT_W'(lanes_r);

  assign hit   = (state_r == ST_SCAN) && chk_res.vld && chk_res.hit;
  assign issue = (state_r == ST_SCAN) && (rd_idx_r < count_r) && !hit;
  assign miss  = (state_r == ST_SCAN) && !hit && (rd_idx_r == count_r) &&
                 !s1_vld_r && !chk_busy;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign rd_addr = rd_idx_r[ADDR_W-1:0];
  assign wr_addr = chk_res.idx[ADDR_W-1:0];
  assign wr_rec.len   = len_r;
  assign wr_rec.start = signed'(START_W'(now_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || miss) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_vld_r    <= 1'b0;
      lane_vld_r  <= '0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      if (in_xfer) begin
        rd_idx_r <= '0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (hit) begin
        lane_vld_r[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      len_r   <= in_item_length;
      now_r   <= in_now_ms;
      count_r <= count_nxt;
    end
    s1_idx_r     <= LANE_IDX_W'(rd_idx_r);
    s1_ent_vld_r <= lane_vld_r[rd_addr];
    if (hit) begin
      res_lane_r  <= LANE_OUT_W'(chk_res.idx);
      res_found_r <= 1'b1;
    end else if (miss) begin
      res_lane_r  <= '0;
      res_found_r <= 1'b0;
    end
    if (out_load) begin
      out_lane_r  <= res_lane_r;
      out_found_r <= res_found_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Lane memory and test pipeline
  // ---------------------------------------------------------------------------
  sla_ram #(
    .WIDTH ($bits(lane_rec_t)),
    .DEPTH (MAX_LANES)
  ) u_lane_mem (
    .clk   (clk),
    .we    (hit),
    .waddr (wr_addr),
    .wdata (wr_rec),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign chk_req.vld = s1_vld_r && !hit;
  assign chk_req.idx = s1_idx_r;

  sla_lane_check #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .flush       (hit),
    .req         (chk_req),
    .ent_valid   (s1_ent_vld_r),
    .rec         (lane_rec_t'(ram_rdata)),
    .now_ms      (now_r),
    .item_length (len_r),
    .travel      (travel_r),
    .res         (chk_res),
    .busy        (chk_busy)
  );

  assign out_valid = out_valid_r;
  assign out_lane  = out_lane_r;
  assign out_found = out_found_r;

`ifndef NO_ASSERTIONS
  // a new item never meets leftovers of the previous scan
  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !s1_vld_r && !chk_busy)
    else $error("item accepted with lane tests in flight");

  // a lane write targets a lane inside the scanned range
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (CNT_W'(chk_res.idx) < count_r))
    else $error("lane write outside scanned range");

  // a refused item reports lane zero
  a_miss_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_lane_r == '0))
    else $error("nonzero lane without a found lane");

  // the read pointer never runs past the lane count
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= count_r))
    else $error("lane read pointer past lane count");
`endif

endmodule

FILE: test/scrolling_lane_allocator_tb.sv
// Self-checking testbench for the scrolling lane allocator: random and directed requests.
`timescale 1ns / 1ps

module scrolling_lane_allocator_tb import sla_pkg::*;;

  // Block geometry, matched to the instance below
  localparam int LANE_SLOTS = 30;
  localparam int LINE_PX    = 1920;

  // Unmapped register index, writes dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

  // Legal crossing times; writes outside are dropped by the block
  localparam int unsigned TRAVEL_LO = 501;
  localparam int unsigned TRAVEL_HI = 29999;

  localparam longint unsigned TIME_MAX = 64'hFF_FFFF_FFFF;

  localparam int IDLE_PCT     = 36;   // chance per cycle that a side idles
  localparam int HOLD_CYCLES  = 300;  // long receiver back-off
  localparam int DRAIN_CYCLES = 40;   // worst-case scan plus pipeline, with margin
  localparam int STALL_LIMIT  = 4000; // cycles without any transfer before giving up
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 60;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now;
  } lane_req_t;

  typedef struct packed {
    logic [LANE_OUT_W-1:0] lane;
    logic                  found;
  } lane_grant_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [LEN_W-1:0]      in_item_length = '0;
  logic [TIME_W-1:0]     in_now_ms      = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [LANE_OUT_W-1:0] out_lane;
  logic                  out_found;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  scrolling_lane_allocator #(
    .MAX_LANES (LANE_SLOTS),
    .LINE_WIDTH(LINE_PX)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item_length(in_item_length),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lane      (out_lane),
    .out_found     (out_found),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers and per-lane occupancy
  // ---------------------------------------------------------------------------
  int unsigned     travel_ms;
  int unsigned     lane_count;
  logic [LEN_W-1:0] occ_len   [LANE_SLOTS];
  longint          occ_start [LANE_SLOTS];

  lane_req_t   req_q[$];    // requests waiting for the driver
  lane_grant_t grant_q[$];  // grants owed by the block, oldest first

  int          reqs_queued  = 0;
  int          grants_seen  = 0;
  int          fail_count   = 0;
  int          granted      = 0;
  int          refused      = 0;
  int          cfg_writes   = 0;
  bit          steady       = 1'b0;  // no idling on either side
  bit          hold_go      = 1'b0;  // asks the receiver for one long back-off
  bit          in_took      = 1'b0;  // input transfer at the last rising edge
  longint unsigned time_base;        // presentation clock of the random traffic

  // First lane in the scan whose previous item is both fully on the line and
  // far enough ahead that the new one cannot catch it; that lane takes the item.
  // Checks are exact cross-multiplied integers, d negative refuses the lane.
  function automatic void assign_lane(input logic [LEN_W-1:0] len,
                                      input logic [TIME_W-1:0] now,
                                      output lane_grant_t g);
    longint t, w, l, p, d;
    int     scan;
    t    = travel_ms;
    w    = LINE_PX;
    l    = len;
    scan = (lane_count > LANE_SLOTS) ? LANE_SLOTS : lane_count;
    g.lane  = '0;
    g.found = 1'b0;
    for (int i = 0; i < scan; i++) begin
      p = occ_len[i];
      d = longint'(now) - occ_start[i];
      if ((t - d) * (w + l) <= w * t && (p + w) * d >= p * t) begin
        occ_len[i]   = len;
        occ_start[i] = longint'(now);
        g.lane       = LANE_OUT_W'(i);
        g.found      = 1'b1;
        return;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: presents queued requests, holds them until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    lane_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (req_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = req_q.pop_front();
        in_valid       <= 1'b1;
        in_item_length <= nxt.len;
        in_now_ms      <= nxt.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin : grant_sink
    int hold_left;
    if (!rst_n) begin
      hold_left = 0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : lane_monitor
    lane_grant_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        grants_seen++;
        if (grant_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected grant lane %0d found %0b", $time, out_lane, out_found);
        end else begin
          want = grant_q.pop_front();
          if (out_lane !== want.lane || out_found !== want.found) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: grant mismatch: expected lane %0d found %0b, got lane %0d found %0b",
                       $time, want.lane, want.found, out_lane, out_found);
          end
        end
      end
      if (in_valid && in_ready) begin
        assign_lane(in_item_length, in_now_ms, want);
        if (want.found) granted++;
        else refused++;
        grant_q.push_back(want);
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side is a hang
  initial begin : stall_guard
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Config write; the shadow follows the block's rules for dropped writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_writes++;
    if (idx == REG_TRAVEL_TIME) begin
      if (data >= TRAVEL_LO && data <= TRAVEL_HI) travel_ms = data;
    end else if (idx == REG_LANES_IN_USE) begin
      lane_count = data[LANES_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lane count with random junk in the unused upper data bits
  task automatic write_lanes(input int unsigned n);
    write_reg(REG_LANES_IN_USE, {10'($urandom), 5'(n)});
  endtask

  task automatic queue_req(input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now);
    req_q.push_back('{len: len, now: now});
    reqs_queued++;
  endtask

  // Idle point: every queued request has produced its grant
  task automatic drain();
    while (grants_seen < reqs_queued) @(negedge clk);
  endtask

  // Mostly a forward-moving clock paced to keep the lanes partly busy,
  // with some big jumps ahead and some requests stamped in the past.
  function automatic lane_req_t next_request();
    lane_req_t   r;
    int unsigned roll, n, span, back;
    n    = (lane_count == 0) ? 1 : ((lane_count > LANE_SLOTS) ? LANE_SLOTS : lane_count);
    span = travel_ms / n;
    roll = $urandom_range(99);
    if (roll < 80) time_base += $urandom_range(span, 0);
    else if (roll < 90) time_base += $urandom_range(4 * travel_ms, travel_ms);
    if (time_base > TIME_MAX) time_base = TIME_MAX;
    r.now = time_base[TIME_W-1:0];
    if (roll >= 90) begin
      back  = $urandom_range(travel_ms, 1);
      r.now = (time_base > back) ? TIME_W'(time_base - back) : '0;
    end
    roll = $urandom_range(99);
    if (roll < 70) r.len = LEN_W'($urandom_range(3000, 0));
    else if (roll < 85) r.len = LEN_W'($urandom);
    else r.len = LEN_W'($urandom_range(40, 0));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    travel_ms  = 10000;
    lane_count = 14;
    for (int i = 0; i < LANE_SLOTS; i++) begin
      occ_len[i]   = 16'd1;
      occ_start[i] = -10000;
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a burst at one instant fills every scanned lane, the
    // tail of it is refused; zero and full-scale lengths included.
    queue_req(16'd0, '0);
    queue_req(16'hFFFF, '0);
    queue_req(16'd1920, '0);
    for (int i = 0; i < 13; i++) queue_req(LEN_W'(100 * i + 7), '0);
    queue_req(16'd1, 40'd20000);
    queue_req(16'd300, 40'd19999);
    drain();

    // No lanes scanned: always refused
    write_lanes(0);
    queue_req(16'd10, 40'd30000);
    queue_req(16'd0, 40'd90000);
    drain();

    // One lane, then a request stamped before that lane's item: time went back
    write_lanes(1);
    queue_req(16'd5, 40'd40000);
    queue_req(16'd5, 40'd39000);
    drain();

    // Shortest crossing time, lane count past the top, and writes that the
    // block must drop: out-of-range times and unmapped indexes.
    write_reg(REG_TRAVEL_TIME, 15'd501);
    write_reg(REG_TRAVEL_TIME, 15'd500);
    write_reg(REG_TRAVEL_TIME, 15'd30000);
    write_reg(REG_TRAVEL_TIME, 15'h7FFF);
    write_reg(REG_TRAVEL_TIME, 15'd0);
    write_reg(REG_SPARE_TOP, 15'h7FFF);
    write_reg(CFG_IDX_W'(REG_LANES_IN_USE + 1), 15'd3);
    write_lanes(31);
    queue_req(16'hFFFF, 40'd50000);
    queue_req(16'hFFFF, 40'd50000);
    queue_req(16'hFFFF, 40'd50001);
    drain();

    time_base = 60000;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          // extremes, with both sides running flat out
          write_reg(REG_TRAVEL_TIME, 15'(TRAVEL_HI));
          write_lanes(30);
          steady = 1'b1;
        end
        1: begin
          write_reg(REG_TRAVEL_TIME, 15'(TRAVEL_LO));
          write_lanes(1);
        end
        2: begin
          write_reg(REG_TRAVEL_TIME, 15'($urandom_range(TRAVEL_HI, TRAVEL_LO)));
          write_lanes(31);
        end
        default: begin
          write_reg(REG_TRAVEL_TIME, 15'($urandom_range(TRAVEL_HI, TRAVEL_LO)));
          if ($urandom_range(1))
            write_reg(REG_TRAVEL_TIME, 15'($urandom_range(TRAVEL_LO - 1, 0)));
          else write_reg(REG_TRAVEL_TIME, 15'($urandom_range(32767, TRAVEL_HI + 1)));
          write_reg(CFG_IDX_W'($urandom_range(15, REG_LANES_IN_USE + 1)), 15'($urandom));
          write_lanes($urandom_range(31, 1));
        end
      endcase
      // last phase runs the clock up against the top of the time field
      if (ph == RAND_PHASES - 1) time_base = TIME_MAX - 30 * longint'(travel_ms);
      for (int k = 0; k < PHASE_ITEMS; k++) req_q.push_back(next_request());
      reqs_queued += PHASE_ITEMS;
      if (ph == RAND_PHASES - 1) queue_req(16'hFFFF, TIME_W'(TIME_MAX));
      // receiver backs off while the sender keeps offering: input must stall
      if (ph == 3) hold_go = 1'b1;
      drain();
      steady = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    if (grant_q.size() != 0) begin
      $display("%0d grants never arrived", grant_q.size());
      fail_count += grant_q.size();
    end

    $display("Sent %0d requests (%0d granted a lane, %0d refused) across %0d config writes,",
             reqs_queued, granted, refused, cfg_writes);
    $display("covering lane counts 0..31, travel 501..29999 and times up to the field max.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
